// ===== rtl/barycentric_normal_interpolator_defines.svh =====
`ifndef BARYCENTRIC_NORMAL_INTERPOLATOR_DEFINES_SVH
`define BARYCENTRIC_NORMAL_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication on clk, off while reset is active.
`define BNI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, off while reset is active.
`define BNI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bni_pkg.sv =====
package bni_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_BITS     = 48;
    localparam int NRM_BITS       = 16;

    // weights carry WGT_FRAC fraction bits, saturate just under four
    localparam int WGT_FRAC  = 16;
    localparam int QUO_BITS  = 2 * WGT_FRAC + 4;
    localparam int ROOT_BITS = QUO_BITS / 2;
    localparam logic [ROOT_BITS-1:0] WGT_MAX = '1;

    localparam int GEOM_LAT  = 6;
    localparam int DS_LAT    = 1 + QUO_BITS + ROOT_BITS;
    localparam int BLEND_LAT = 3;

    typedef struct packed {
        logic [FIELD_BITS-1:0] vertex_a;
        logic [FIELD_BITS-1:0] vertex_b;
        logic [FIELD_BITS-1:0] vertex_c;
        logic [FIELD_BITS-1:0] normal_a;
        logic [FIELD_BITS-1:0] normal_b;
        logic [FIELD_BITS-1:0] normal_c;
        logic [FIELD_BITS-1:0] query_point;
    } query_t;

    typedef struct packed {
        logic signed [NRM_BITS-1:0] out_normal_x;
        logic signed [NRM_BITS-1:0] out_normal_y;
        logic signed [NRM_BITS-1:0] out_normal_z;
        logic                       degenerate;
    } result_t;

    typedef logic signed [NRM_BITS-1:0] nrm_t;
    typedef nrm_t [2:0] nrm_vec_t;
    typedef nrm_vec_t [2:0] nrm_set_t;

endpackage

// ===== rtl/bni_geom.sv =====
module bni_geom
    import bni_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [FIELD_BITS-1:0]     vertex_a,
    input  logic [FIELD_BITS-1:0]     vertex_b,
    input  logic [FIELD_BITS-1:0]     vertex_c,
    input  logic [FIELD_BITS-1:0]     point,
    output logic                      out_valid,
    output logic [4*COORD_BITS+5:0]   den,
    output logic [4*COORD_BITS+5:0]   num_s,
    output logic [4*COORD_BITS+5:0]   num_t
);

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int XW  = PW + 1;
    localparam int MW  = 2 * COORD_BITS + 2;
    localparam int HW  = MW / 2;
    localparam int SW  = 2 * MW;
    localparam int LW  = SW + 2;
    localparam int PKW = (3 * COORD_BITS > FIELD_BITS) ? 3 * COORD_BITS : FIELD_BITS;

    typedef logic signed [DW-1:0] dif_t;
    typedef dif_t [2:0] dvec_t;
    typedef logic signed [PW-1:0] prd_t;
    typedef prd_t [1:0] ppair_t;
    typedef ppair_t [2:0] pcross_t;
    typedef logic [MW-1:0] mag_t;
    typedef logic [SW-1:0] sq_t;
    typedef logic [LW-1:0] len_t;

    logic [GEOM_LAT-1:0] vld_reg;
    dvec_t   ab_reg, ac_reg, bc_reg, bp_reg, cp_reg;
    dvec_t   u_w [3];
    dvec_t   v_w [3];
    pcross_t prod_reg [3];
    mag_t    mag_reg [3][3];
    mag_t    pp_reg [3][3][3];
    sq_t     sq_reg [3][3];
    len_t    len_reg [3];

    function automatic dvec_t sub_vec(input logic [FIELD_BITS-1:0] p,
                                      input logic [FIELD_BITS-1:0] q);
        dvec_t d;
        logic [PKW-1:0] pe;
        logic [PKW-1:0] qe;
        pe = PKW'(p);
        qe = PKW'(q);
        for (int k = 0; k < 3; k++)
        begin
            d[k] = DW'(signed'(pe[k*COORD_BITS +: COORD_BITS]))
                 - DW'(signed'(qe[k*COORD_BITS +: COORD_BITS]));
        end
        return d;
    endfunction

    function automatic prd_t mul_d(input dif_t a, input dif_t b);
        return PW'(a) * PW'(b);
    endfunction

    function automatic pcross_t cross_terms(input dvec_t u, input dvec_t v);
        pcross_t p;
        p[0][0] = mul_d(u[1], v[2]);
        p[0][1] = mul_d(u[2], v[1]);
        p[1][0] = mul_d(u[2], v[0]);
        p[1][1] = mul_d(u[0], v[2]);
        p[2][0] = mul_d(u[0], v[1]);
        p[2][1] = mul_d(u[1], v[0]);
        return p;
    endfunction

    function automatic mag_t mag_of(input prd_t x, input prd_t y);
        logic signed [XW-1:0] c;
        c = XW'(x) - XW'(y);
        return c[XW-1] ? MW'(-c) : MW'(c);
    endfunction

    // area BCP over ABC for s, area CAP over ABC for t
    always_comb
    begin
        u_w[0] = ab_reg;
        v_w[0] = ac_reg;
        u_w[1] = bc_reg;
        v_w[1] = bp_reg;
        u_w[2] = ac_reg;
        v_w[2] = cp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[GEOM_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab_reg <= sub_vec(vertex_b, vertex_a);
            ac_reg <= sub_vec(vertex_c, vertex_a);
            bc_reg <= sub_vec(vertex_c, vertex_b);
            bp_reg <= sub_vec(point, vertex_b);
            cp_reg <= sub_vec(point, vertex_c);
            for (int x = 0; x < 3; x++)
            begin
                prod_reg[x] <= cross_terms(u_w[x], v_w[x]);
                for (int k = 0; k < 3; k++)
                begin
                    mag_reg[x][k] <= mag_of(prod_reg[x][k][0], prod_reg[x][k][1]);
                    // square split into halves to keep each multiplier narrow
                    pp_reg[x][k][0] <= MW'(mag_reg[x][k][HW-1:0]) * MW'(mag_reg[x][k][HW-1:0]);
                    pp_reg[x][k][1] <= MW'(mag_reg[x][k][MW-1:HW]) * MW'(mag_reg[x][k][HW-1:0]);
                    pp_reg[x][k][2] <= MW'(mag_reg[x][k][MW-1:HW]) * MW'(mag_reg[x][k][MW-1:HW]);
                    sq_reg[x][k] <= (SW'(pp_reg[x][k][2]) << MW)
                                  + (SW'(pp_reg[x][k][1]) << (HW + 1))
                                  + SW'(pp_reg[x][k][0]);
                end
                len_reg[x] <= LW'(sq_reg[x][0]) + LW'(sq_reg[x][1]) + LW'(sq_reg[x][2]);
            end
        end
    end

    assign out_valid = vld_reg[GEOM_LAT-1];
    assign den       = len_reg[0];
    assign num_s     = len_reg[1];
    assign num_t     = len_reg[2];

endmodule

// ===== rtl/bni_weight.sv =====
module bni_weight
    import bni_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [4*COORD_BITS+5:0] num,
    input  logic [4*COORD_BITS+5:0] den,
    output logic                    out_valid,
    output logic [ROOT_BITS-1:0]    weight
);

    localparam int LW  = 4 * COORD_BITS + 6;
    localparam int NLO = QUO_BITS - 2 * WGT_FRAC;
    localparam int SRW = ROOT_BITS + 2;

    logic [DS_LAT-1:0] vld_reg;

    // long division, one quotient bit per stage
    logic [LW-1:0]       rem_reg  [QUO_BITS+1];
    logic [LW-1:0]       dvs_reg  [QUO_BITS+1];
    logic [NLO-1:0]      nlo_reg  [QUO_BITS+1];
    logic [QUO_BITS-1:0] quo_reg  [QUO_BITS+1];
    logic                dsat_reg [QUO_BITS+1];
    logic [LW:0]         shf_w    [QUO_BITS];
    logic [LW-1:0]       rem_next [QUO_BITS];
    logic [QUO_BITS-1:0] qbit_next;

    // square root, one root bit per stage
    logic [QUO_BITS-1:0]  rad_reg   [ROOT_BITS];
    logic [SRW-1:0]       srem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg  [ROOT_BITS];
    logic                 rsat_reg  [ROOT_BITS];
    logic [QUO_BITS-1:0]  rad_in    [ROOT_BITS];
    logic [SRW-1:0]       srem_in   [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_in   [ROOT_BITS];
    logic                 rsat_in   [ROOT_BITS];
    logic [SRW+1:0]       sshf_w    [ROOT_BITS];
    logic [SRW+1:0]       strial_w  [ROOT_BITS];
    logic [SRW-1:0]       srem_next [ROOT_BITS];
    logic [ROOT_BITS-1:0] rbit_next;

    always_comb
    begin
        for (int k = 0; k < QUO_BITS; k++)
        begin
            shf_w[k]     = {rem_reg[k], nlo_reg[k][NLO-1]};
            qbit_next[k] = shf_w[k] >= {1'b0, dvs_reg[k]};
            rem_next[k]  = qbit_next[k] ? LW'(shf_w[k] - {1'b0, dvs_reg[k]})
                                        : shf_w[k][LW-1:0];
        end
    end

    always_comb
    begin
        rad_in[0]  = quo_reg[QUO_BITS];
        srem_in[0] = '0;
        root_in[0] = '0;
        rsat_in[0] = dsat_reg[QUO_BITS];
        for (int j = 1; j < ROOT_BITS; j++)
        begin
            rad_in[j]  = rad_reg[j-1];
            srem_in[j] = srem_reg[j-1];
            root_in[j] = root_reg[j-1];
            rsat_in[j] = rsat_reg[j-1];
        end
        for (int j = 0; j < ROOT_BITS; j++)
        begin
            sshf_w[j]    = {srem_in[j], rad_in[j][QUO_BITS-1 -: 2]};
            strial_w[j]  = {2'b00, root_in[j], 2'b01};
            rbit_next[j] = sshf_w[j] >= strial_w[j];
            srem_next[j] = rbit_next[j] ? SRW'(sshf_w[j] - strial_w[j]) : SRW'(sshf_w[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DS_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient of at least sixteen saturates; the division then runs on junk
            dsat_reg[0] <= {{NLO{1'b0}}, num} >= {den, {NLO{1'b0}}};
            rem_reg[0]  <= LW'(num >> NLO);
            dvs_reg[0]  <= den;
            nlo_reg[0]  <= num[NLO-1:0];
            quo_reg[0]  <= '0;
            for (int k = 0; k < QUO_BITS; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                dvs_reg[k+1]  <= dvs_reg[k];
                nlo_reg[k+1]  <= {nlo_reg[k][NLO-2:0], 1'b0};
                quo_reg[k+1]  <= {quo_reg[k][QUO_BITS-2:0], qbit_next[k]};
                dsat_reg[k+1] <= dsat_reg[k];
            end
            for (int j = 0; j < ROOT_BITS; j++)
            begin
                rad_reg[j]  <= rad_in[j] << 2;
                srem_reg[j] <= srem_next[j];
                root_reg[j] <= {root_in[j][ROOT_BITS-2:0], rbit_next[j]};
                rsat_reg[j] <= rsat_in[j];
            end
        end
    end

    assign out_valid = vld_reg[DS_LAT-1];
    assign weight    = rsat_reg[ROOT_BITS-1] ? WGT_MAX : root_reg[ROOT_BITS-1];

endmodule

// ===== rtl/bni_blend.sv =====
module bni_blend
    import bni_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [ROOT_BITS-1:0] s_wgt,
    input  logic [ROOT_BITS-1:0] t_wgt,
    input  nrm_set_t             nrm,
    input  logic                 deg,
    output logic                 out_valid,
    output result_t              result
);

    localparam int WW  = ROOT_BITS + 2;
    localparam int PRW = WW + NRM_BITS;
    localparam int ACW = PRW + 2;
    localparam int SHW = ACW - WGT_FRAC;

    localparam logic signed [WW-1:0]  W_ONE  = WW'(1 << WGT_FRAC);
    localparam logic signed [ACW-1:0] HALF   = ACW'(1 << (WGT_FRAC - 1));
    localparam logic signed [SHW-1:0] NRM_HI = SHW'((1 << (NRM_BITS - 1)) - 1);
    localparam logic signed [SHW-1:0] NRM_LO = -SHW'(1 << (NRM_BITS - 1));

    typedef logic signed [PRW-1:0] wprd_t;

    logic [BLEND_LAT-1:0]  vld_reg;
    logic signed [WW-1:0]  wv_reg [3];
    nrm_set_t              nrm_reg;
    logic                  deg1_reg;
    logic                  deg2_reg;
    wprd_t                 prd_reg [3][3];
    logic signed [WW-1:0]  w_next;
    logic signed [ACW-1:0] acc_w [3];
    logic signed [SHW-1:0] shf_w [3];
    nrm_t                  cmp_w [3];
    result_t               res_next;
    result_t               res_reg;

    function automatic wprd_t wmul(input logic signed [WW-1:0] w, input nrm_t n);
        return PRW'(w) * PRW'(n);
    endfunction

    assign w_next = W_ONE - signed'(WW'(s_wgt)) - signed'(WW'(t_wgt));

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc_w[k] = ACW'(prd_reg[0][k]) + ACW'(prd_reg[1][k])
                     + ACW'(prd_reg[2][k]) + HALF;
            shf_w[k] = SHW'(acc_w[k] >>> WGT_FRAC);
            if (deg2_reg)
            begin
                cmp_w[k] = '0;
            end
            else if (shf_w[k] > NRM_HI)
            begin
                cmp_w[k] = NRM_BITS'(NRM_HI);
            end
            else if (shf_w[k] < NRM_LO)
            begin
                cmp_w[k] = NRM_BITS'(NRM_LO);
            end
            else
            begin
                cmp_w[k] = NRM_BITS'(shf_w[k]);
            end
        end
        res_next.out_normal_x = cmp_w[0];
        res_next.out_normal_y = cmp_w[1];
        res_next.out_normal_z = cmp_w[2];
        res_next.degenerate   = deg2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[BLEND_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wv_reg[0] <= signed'(WW'(s_wgt));
            wv_reg[1] <= signed'(WW'(t_wgt));
            wv_reg[2] <= w_next;
            nrm_reg   <= nrm;
            deg1_reg  <= deg;
            for (int v = 0; v < 3; v++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prd_reg[v][k] <= wmul(wv_reg[v], nrm_reg[v][k]);
                end
            end
            deg2_reg <= deg1_reg;
            res_reg  <= res_next;
        end
    end

    assign out_valid = vld_reg[BLEND_LAT-1];
    assign result    = res_reg;

endmodule

// ===== rtl/barycentric_normal_interpolator.sv =====
// Channel   Payload    Handshake                   Transfer when
// query     query_t    query_valid / query_stall   query_valid && !query_stall
// result    result_t   result_valid / result_stall result_valid && !result_stall
//
// One query enters per cycle unless stalled. The pipeline has 6 geometry
// stages, 55 weight stages (one setup stage, 36 divide steps and 18 root
// steps; one divide or root bit per stage) and 3 blend stages, which all
// advance together and freeze only while a result waits under result_stall;
// query_stall rises with it. Reset clears only valid bits; no clearing pass.
`include "barycentric_normal_interpolator_defines.svh"

module barycentric_normal_interpolator
    import bni_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    query_valid,
    output logic    query_stall,
    input  query_t  query,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int LW      = 4 * COORD_BITS + 6;
    localparam int NRM_LAT = GEOM_LAT + DS_LAT;

    logic                 advance;
    logic                 geom_valid;
    logic [LW-1:0]        geom_den;
    logic [LW-1:0]        geom_num_s;
    logic [LW-1:0]        geom_num_t;
    logic                 den_zero;
    logic                 wgt_s_valid;
    logic                 wgt_t_valid;
    logic [ROOT_BITS-1:0] wgt_s;
    logic [ROOT_BITS-1:0] wgt_t;
    nrm_set_t             nrm_in;
    nrm_set_t             nrm_dly_reg [NRM_LAT];
    logic [DS_LAT-1:0]    deg_dly_reg;

    // hold every stage while the finished result is refused
    assign advance     = !(result_valid && result_stall);
    assign query_stall = !advance;

    assign nrm_in[0] = nrm_vec_t'(query.normal_a);
    assign nrm_in[1] = nrm_vec_t'(query.normal_b);
    assign nrm_in[2] = nrm_vec_t'(query.normal_c);

    bni_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (query_valid),
        .vertex_a  (query.vertex_a),
        .vertex_b  (query.vertex_b),
        .vertex_c  (query.vertex_c),
        .point     (query.query_point),
        .out_valid (geom_valid),
        .den       (geom_den),
        .num_s     (geom_num_s),
        .num_t     (geom_num_t)
    );

    assign den_zero = (geom_den == '0);

    bni_weight #(
        .COORD_BITS (COORD_BITS)
    ) u_weight_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (geom_valid),
        .num       (geom_num_s),
        .den       (geom_den),
        .out_valid (wgt_s_valid),
        .weight    (wgt_s)
    );

    bni_weight #(
        .COORD_BITS (COORD_BITS)
    ) u_weight_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (geom_valid),
        .num       (geom_num_t),
        .den       (geom_den),
        .out_valid (wgt_t_valid),
        .weight    (wgt_t)
    );

    // vertex normals and the zero-area flag ride alongside the weights
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            nrm_dly_reg[0] <= nrm_in;
            for (int i = 1; i < NRM_LAT; i++)
            begin
                nrm_dly_reg[i] <= nrm_dly_reg[i-1];
            end
            deg_dly_reg <= {deg_dly_reg[DS_LAT-2:0], den_zero};
        end
    end

    bni_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (wgt_s_valid),
        .s_wgt     (wgt_s),
        .t_wgt     (wgt_t),
        .nrm       (nrm_dly_reg[NRM_LAT-1]),
        .deg       (deg_dly_reg[DS_LAT-1]),
        .out_valid (result_valid),
        .result    (result)
    );

    `BNI_ASSERT_NOW(a_deg_zero, result_valid && result.degenerate, result.out_normal_x == 16'sd0 && result.out_normal_y == 16'sd0 && result.out_normal_z == 16'sd0, "degenerate result carries a nonzero normal")
    `BNI_ASSERT_NOW(a_stall_back, result_valid && result_stall, query_stall, "query taken while result is held")
    `BNI_ASSERT_NOW(a_wgt_lockstep, 1'b1, wgt_s_valid == wgt_t_valid, "weight units out of step")
    `BNI_ASSERT_NEXT(a_freeze, result_valid && result_stall, $stable(wgt_s_valid) && $stable(geom_valid), "pipeline moved during stall")

endmodule
